// ----- hw/rtl/hbkrd_pkg.sv -----
// Package of the boot keyboard report differ: types, constants and sizes.
`default_nettype none

package hbkrd_pkg;

    // Number of key slots in one boot report.
    localparam int KEY_SLOTS = 6;
    // Events per report at most: one press and one release per slot.
    localparam int EVENT_SLOTS = 2 * KEY_SLOTS;
    localparam int EVENT_IDX_W = $clog2(EVENT_SLOTS);
    localparam int SLOT_IDX_W = EVENT_IDX_W - 1;

    // Depth of the job queue between front and back (a power of two).
    localparam int JOB_DEPTH = 2;
    localparam int JOB_PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
    localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

    // Rollover error code, which never counts as a match.
    localparam logic [7:0] ROLLOVER_CODE = 8'd1;

    // Event kinds.
    localparam logic KIND_PRESS = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    typedef logic [KEY_SLOTS-1:0][7:0] t_slots;

    // One input word: a boot keyboard report.
    typedef struct packed {
        logic [7:0] modifier;
        logic [7:0] slot_0;
        logic [7:0] slot_1;
        logic [7:0] slot_2;
        logic [7:0] slot_3;
        logic [7:0] slot_4;
        logic [7:0] slot_5;
    } t_report;

    // One output word: a key event.
    typedef struct packed {
        logic       event_kind;
        logic [7:0] key_code;
        logic [7:0] modifier_now;
        logic       last;
    } t_event;

    // A classified report: the codes and one bit for each event to emit.
    // Bit 2*i is the press of slot i, bit 2*i+1 the release of slot i.
    typedef struct packed {
        logic [7:0]             modifier;
        t_slots                 cur;
        t_slots                 prev;
        logic [EVENT_SLOTS-1:0] mask;
    } t_job;

endpackage

`default_nettype wire

// ----- hw/rtl/hid_boot_keyboard_report_diff.sv -----
// Top level of the boot keyboard report differ.
//
// Input channel: a report word (modifier byte and six key slots) is taken
// at a clock edge with push high and full low. Output channel: while empty
// is low the oldest event word (kind, key code, modifier, last flag) is on
// o_event; it is taken at a clock edge with pop high.
// Each report is classified in the cycle it is taken and, if it causes any
// event, queued as a job in a two-entry queue. The back part emits the job's
// events one per cycle while the receiver takes them; a report causes 0 to
// 12 events. Reports are taken every cycle while the job queue has room; the
// sustained rate is set by the back part's one event per cycle.
// The last event of a report carries last = 1; a report that equals the
// stored one and holds no rollover code produces nothing.
// Synchronous reset clears the stored previous slots to zero and empties
// the queue and the output register. When the receiver stalls, the output
// register holds its word, the back part waits, the queue fills and full
// rises.
`default_nettype none

module hid_boot_keyboard_report_diff (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire hbkrd_pkg::t_report i_report,
    output logic                    empty,
    input  wire logic               pop,
    output hbkrd_pkg::t_event       o_event
);

    logic w_job_push;
    logic w_job_full;
    logic w_job_pop;
    logic w_job_empty;
    hbkrd_pkg::t_job w_job_in;
    hbkrd_pkg::t_job w_job_out;

    // Classification of incoming reports.
    hbkrd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_report   (i_report),
        .i_job_full (w_job_full),
        .o_full     (full),
        .o_job_push (w_job_push),
        .o_job      (w_job_in)
    );

    // Job queue decoupling the two parts.
    hbkrd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_data  (w_job_in),
        .o_full  (w_job_full),
        .i_pop   (w_job_pop),
        .o_empty (w_job_empty),
        .o_data  (w_job_out)
    );

    // Event emission.
    hbkrd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (w_job_empty),
        .i_job       (w_job_out),
        .o_job_pop   (w_job_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_event     (o_event)
    );

`ifndef NO_ASSERTIONS
    // After reset nothing is waiting on either side.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("block not cleared by reset");

    // The front never pushes a job into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_job_push && w_job_full))
        else $error("job pushed into full queue");

    // The back never pops a job from an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_job_pop && w_job_empty))
        else $error("job popped from empty queue");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/hbkrd_front.sv -----
// Front part: accepts reports, compares them with the previous slots, queues jobs.
`default_nettype none

module hbkrd_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire hbkrd_pkg::t_report i_report,
    input  wire logic              i_job_full,
    output logic                   o_full,
    output logic                   o_job_push,
    output hbkrd_pkg::t_job        o_job
);

    hbkrd_pkg::t_slots r_prev;
    hbkrd_pkg::t_slots w_cur;
    logic [hbkrd_pkg::EVENT_SLOTS-1:0] w_mask;
    logic w_accept;

    // Unpack the report's slots into an array.
    always_comb begin
        w_cur[0] = i_report.slot_0;
        w_cur[1] = i_report.slot_1;
        w_cur[2] = i_report.slot_2;
        w_cur[3] = i_report.slot_3;
        w_cur[4] = i_report.slot_4;
        w_cur[5] = i_report.slot_5;
    end

    // Compare every current slot with every previous slot in parallel.
    always_comb begin
        logic held;
        logic kept;
        for (int i = 0; i < hbkrd_pkg::KEY_SLOTS; i++) begin
            held = 1'b0;
            kept = 1'b0;
            for (int j = 0; j < hbkrd_pkg::KEY_SLOTS; j++) begin
                if (w_cur[i] == r_prev[j] && w_cur[i] != hbkrd_pkg::ROLLOVER_CODE) begin
                    held = 1'b1;
                end
                if (r_prev[i] == w_cur[j] && r_prev[i] != hbkrd_pkg::ROLLOVER_CODE) begin
                    kept = 1'b1;
                end
            end
            w_mask[2*i]     = !held;
            w_mask[2*i + 1] = !kept;
        end
    end

    assign o_full     = i_job_full;
    assign w_accept   = i_push && !i_job_full;
    // A report that causes no event takes no queue entry.
    assign o_job_push = w_accept && (w_mask != '0);

    always_comb begin
        o_job.modifier = i_report.modifier;
        o_job.cur      = w_cur;
        o_job.prev     = r_prev;
        o_job.mask     = w_mask;
    end

    // The stored slots are replaced by every accepted report.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (w_accept) begin
            r_prev <= w_cur;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/hbkrd_fifo.sv -----
// Short job queue between the front and the back part.
`default_nettype none

module hbkrd_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire hbkrd_pkg::t_job i_data,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_empty,
    output hbkrd_pkg::t_job      o_data
);

    hbkrd_pkg::t_job r_mem [hbkrd_pkg::JOB_DEPTH];
    logic [hbkrd_pkg::JOB_PTR_W-1:0] r_wr_ptr;
    logic [hbkrd_pkg::JOB_PTR_W-1:0] r_rd_ptr;
    logic [hbkrd_pkg::JOB_CNT_W-1:0] r_count;
    logic w_wr;
    logic w_rd;

    assign o_full  = (r_count == hbkrd_pkg::JOB_CNT_W'(hbkrd_pkg::JOB_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers wrap naturally because the depth is a power of two.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/hbkrd_back.sv -----
// Back part: walks a job's event bits, one event per cycle unless output stalls.
`default_nettype none

module hbkrd_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_job_empty,
    input  wire hbkrd_pkg::t_job i_job,
    output logic                 o_job_pop,
    output logic                 o_empty,
    input  wire logic            i_pop,
    output hbkrd_pkg::t_event    o_event
);

    hbkrd_pkg::t_job r_job;
    logic [hbkrd_pkg::EVENT_SLOTS-1:0] r_mask;
    logic [hbkrd_pkg::EVENT_SLOTS-1:0] n_mask;
    logic [hbkrd_pkg::EVENT_IDX_W-1:0] w_idx;
    logic [hbkrd_pkg::SLOT_IDX_W-1:0]  w_slot;
    hbkrd_pkg::t_event r_out;
    logic r_out_valid;
    logic w_out_free;
    logic w_emit;
    logic w_kind;

    // Lowest pending event bit.
    always_comb begin
        w_idx = '0;
        for (int k = hbkrd_pkg::EVENT_SLOTS - 1; k >= 0; k--) begin
            if (r_mask[k]) begin
                w_idx = hbkrd_pkg::EVENT_IDX_W'(k);
            end
        end
    end

    assign w_slot     = w_idx[hbkrd_pkg::EVENT_IDX_W-1:1];
    assign w_kind     = w_idx[0];
    assign w_out_free = !r_out_valid || i_pop;
    assign w_emit     = (r_mask != '0) && w_out_free;

    // Remaining bits once the current one has gone out.
    always_comb begin
        n_mask = r_mask;
        if (w_emit) begin
            n_mask[w_idx] = 1'b0;
        end
    end

    // Take the next job as soon as the current one is finished.
    assign o_job_pop = !i_job_empty && (n_mask == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (o_job_pop) begin
            r_mask <= i_job.mask;
        end else begin
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job;
        end
    end

    // Output register: the event word waits here until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out.event_kind   <= w_kind;
            r_out.key_code     <= (w_kind == hbkrd_pkg::KIND_RELEASE) ?
                                  r_job.prev[w_slot] : r_job.cur[w_slot];
            r_out.modifier_now <= r_job.modifier;
            r_out.last         <= (n_mask == '0);
        end
    end

    assign o_empty = !r_out_valid;
    assign o_event = r_out;

endmodule

`default_nettype wire

// ----- tb/sv/tb_hid_boot_keyboard_report_diff.sv -----
// Testbench of the boot keyboard report differ: directed and random reports, checked per event.
`timescale 1ns / 100ps

module tb_hid_boot_keyboard_report_diff;

    // Cycles without any accepted word before the run is declared hung.
    localparam int STUCK_LIMIT = 2000;
    // Cycles to wait after the last event, covering the back part's latency.
    localparam int DRAIN_CYCLES = 20;
    localparam int WORDS_PER_PHASE = 28;

    logic                i_clk;
    logic                i_rst_n;
    logic                push;
    logic                full;
    hbkrd_pkg::t_report  i_report;
    logic                empty;
    logic                pop;
    hbkrd_pkg::t_event   o_event;

    // Reports waiting to be offered, and events still to come out.
    hbkrd_pkg::t_report report_backlog [$];
    hbkrd_pkg::t_event  expected_events [$];
    // Key slots of the last accepted report, as the differ should hold them.
    logic [7:0] stored_slots [hbkrd_pkg::KEY_SLOTS];

    int sender_idle_pct;
    int receiver_stall_pct;
    int error_count;
    int reports_taken;
    int events_seen;
    int stuck_cycles;

    hid_boot_keyboard_report_diff dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_report (i_report),
        .empty    (empty),
        .pop      (pop),
        .o_event  (o_event)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Works out the key events of one report and moves its slots into the stored state.
    function automatic void predict_events(input hbkrd_pkg::t_report rep);
        logic [7:0]        now_slots [hbkrd_pkg::KEY_SLOTS];
        logic              is_new;
        logic              is_gone;
        int                produced;
        hbkrd_pkg::t_event ev;
        now_slots[0] = rep.slot_0;
        now_slots[1] = rep.slot_1;
        now_slots[2] = rep.slot_2;
        now_slots[3] = rep.slot_3;
        now_slots[4] = rep.slot_4;
        now_slots[5] = rep.slot_5;
        produced = 0;
        for (int i = 0; i < hbkrd_pkg::KEY_SLOTS; i++) begin
            is_new = 1'b1;
            is_gone = 1'b1;
            // The rollover code never matches, so it always shows up as an event.
            for (int j = 0; j < hbkrd_pkg::KEY_SLOTS; j++) begin
                if (now_slots[i] == stored_slots[j]
                        && now_slots[i] != hbkrd_pkg::ROLLOVER_CODE)
                    is_new = 1'b0;
                if (stored_slots[i] == now_slots[j]
                        && stored_slots[i] != hbkrd_pkg::ROLLOVER_CODE)
                    is_gone = 1'b0;
            end
            if (is_new) begin
                ev.event_kind = hbkrd_pkg::KIND_PRESS;
                ev.key_code = now_slots[i];
                ev.modifier_now = rep.modifier;
                ev.last = 1'b0;
                expected_events.push_back(ev);
                produced++;
            end
            if (is_gone) begin
                ev.event_kind = hbkrd_pkg::KIND_RELEASE;
                ev.key_code = stored_slots[i];
                ev.modifier_now = rep.modifier;
                ev.last = 1'b0;
                expected_events.push_back(ev);
                produced++;
            end
        end
        // Flag the final event of this report.
        if (produced > 0) begin
            ev = expected_events.pop_back();
            ev.last = 1'b1;
            expected_events.push_back(ev);
        end
        stored_slots = now_slots;
    endfunction

    task automatic queue_report(input logic [7:0] mod, input logic [7:0] s0, s1, s2, s3,
                                input logic [7:0] s4, s5);
        hbkrd_pkg::t_report rep;
        rep.modifier = mod;
        rep.slot_0 = s0;
        rep.slot_1 = s1;
        rep.slot_2 = s2;
        rep.slot_3 = s3;
        rep.slot_4 = s4;
        rep.slot_5 = s5;
        report_backlog.push_back(rep);
    endtask

    // Waits until every report is taken and every event has come out.
    task automatic wait_idle();
        while (report_backlog.size() != 0 || push || expected_events.size() != 0)
            @(negedge i_clk);
    endtask

    // Driver: offers the backlog one word at a time, holding a word until it is taken.
    always @(posedge i_clk) begin : report_driver
        if (!i_rst_n) begin
            push <= 1'b0;
            for (int k = 0; k < hbkrd_pkg::KEY_SLOTS; k++)
                stored_slots[k] = 8'h00;
        end else begin
            if (push && !full) begin
                predict_events(i_report);
                reports_taken++;
            end
            if (!push || !full) begin
                if (report_backlog.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                    i_report <= report_backlog.pop_front();
                    push <= 1'b1;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each taken event word with the oldest expected one.
    always @(posedge i_clk) begin : event_monitor
        hbkrd_pkg::t_event want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                events_seen++;
                if (expected_events.size() == 0) begin
                    $display("%0t: unexpected event: kind %0d code %02h mod %02h last %0d",
                             $time, o_event.event_kind, o_event.key_code,
                             o_event.modifier_now, o_event.last);
                    error_count++;
                end else begin
                    want = expected_events.pop_front();
                    if (o_event.event_kind !== want.event_kind
                            || o_event.key_code !== want.key_code
                            || o_event.modifier_now !== want.modifier_now
                            || o_event.last !== want.last) begin
                        $display("%0t: mismatch: expected kind %0d code %02h mod %02h last %0d",
                                 $time, want.event_kind, want.key_code, want.modifier_now,
                                 want.last);
                        $display("%0t: mismatch:   actual kind %0d code %02h mod %02h last %0d",
                                 $time, o_event.event_kind, o_event.key_code,
                                 o_event.modifier_now, o_event.last);
                        error_count++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Watchdog: ends the run when no word moves for too long.
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no word accepted for %0d cycles", $time, STUCK_LIMIT);
            $display("tb_hid_boot_keyboard_report_diff: errors");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [7:0] typing [hbkrd_pkg::KEY_SLOTS];
        int         roll;
        int         k;
        i_rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_report = '0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        error_count = 0;
        reports_taken = 0;
        events_seen = 0;
        stuck_cycles = 0;
        for (int i = 0; i < hbkrd_pkg::KEY_SLOTS; i++)
            typing[i] = 8'h00;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed reports: empty state, extremes, rollover and unchanged reports.
        queue_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_report(8'hFF, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_report(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_report(8'hAA, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01);
        queue_report(8'h55, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01);
        queue_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_report(8'h02, 8'h04, 8'h04, 8'h05, 8'h00, 8'h00, 8'h00);
        queue_report(8'h20, 8'h05, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_report(8'h20, 8'h05, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_report(8'h01, 8'h01, 8'h05, 8'h80, 8'h00, 8'h00, 8'h00);
        queue_report(8'h80, 8'h80, 8'h7F, 8'hAA, 8'h55, 8'h02, 8'h03);
        queue_report(8'h7F, 8'h03, 8'h02, 8'h55, 8'hAA, 8'h7F, 8'h80);
        queue_report(8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_report(8'h08, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01);
        queue_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        wait_idle();

        // Random reports in four handshake phases.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct = 67;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 67;
                end
                default: begin
                    sender_idle_pct = 17;
                    receiver_stall_pct = 17;
                end
            endcase
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                roll = $urandom_range(99);
                if (roll < 15) begin
                    // Noise: arbitrary bytes in every slot.
                    for (int i = 0; i < hbkrd_pkg::KEY_SLOTS; i++)
                        typing[i] = 8'($urandom_range(255));
                end else if (roll < 23) begin
                    // Few distinct codes, so duplicates, empties and rollover mix.
                    for (int i = 0; i < hbkrd_pkg::KEY_SLOTS; i++)
                        typing[i] = 8'($urandom_range(3));
                end else if (roll < 27) begin
                    for (int i = 0; i < hbkrd_pkg::KEY_SLOTS; i++)
                        typing[i] = hbkrd_pkg::ROLLOVER_CODE;
                end else begin
                    // Typing: press into the first free slot, release with shift, or hold.
                    case ($urandom_range(2))
                        0: begin
                            k = 0;
                            while (k < hbkrd_pkg::KEY_SLOTS && typing[k] != 8'h00)
                                k++;
                            if (k < hbkrd_pkg::KEY_SLOTS)
                                typing[k] = 8'($urandom_range(4, 255));
                        end
                        1: begin
                            k = $urandom_range(hbkrd_pkg::KEY_SLOTS - 1);
                            if (typing[k] != 8'h00) begin
                                for (int j = k; j < hbkrd_pkg::KEY_SLOTS - 1; j++)
                                    typing[j] = typing[j + 1];
                                typing[hbkrd_pkg::KEY_SLOTS - 1] = 8'h00;
                            end
                        end
                        default: ;
                    endcase
                end
                queue_report(8'($urandom_range(255)), typing[0], typing[1], typing[2],
                             typing[3], typing[4], typing[5]);
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_events.size() != 0) begin
            $display("%0t: %0d expected events never came out", $time,
                     expected_events.size());
            error_count++;
        end
        $display("Run covered %0d reports and %0d key events: a directed pass",
                 reports_taken, events_seen);
        $display("and random reports under four handshake phases.");
        if (error_count == 0) begin
            $display("tb_hid_boot_keyboard_report_diff: clean");
        end else begin
            $display("tb_hid_boot_keyboard_report_diff: errors");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/hbkrd_pkg.sv
hw/rtl/hbkrd_front.sv
hw/rtl/hbkrd_fifo.sv
hw/rtl/hbkrd_back.sv
hw/rtl/hid_boot_keyboard_report_diff.sv
tb/sv/tb_hid_boot_keyboard_report_diff.sv
